### sv/mfrag_pkg.sv
// Package for the message fragmenter: widths, fragment size constants,
// reciprocal constants for the fragment count, the queue item and the sequencer phases.
// No dependencies.
package mfrag_pkg;

  localparam int FRAME_BYTES   = 100;
  localparam int HDR_BYTES     = 2;
  localparam int PAYLOAD_BYTES = FRAME_BYTES - HDR_BYTES;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;

  localparam logic [BYTE_W-1:0] PAYLOAD_LIM = BYTE_W'(PAYLOAD_BYTES);
  localparam logic [BYTE_W-1:0] SEQ_FIRST   = BYTE_W'(1);
  localparam logic [BYTE_W-1:0] COUNT_MAX   = BYTE_W'(255);

  // floor(m / PAYLOAD_BYTES) == (m * RECIP_MULT) >> RECIP_SHIFT for every 16-bit m
  localparam int RECIP_SHIFT = LEN_W + $clog2(PAYLOAD_BYTES);
  localparam int RECIP_W     = LEN_W + 2;
  localparam int PROD_W      = LEN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PAYLOAD_BYTES) - 64'd1) / 64'(PAYLOAD_BYTES));

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] dest;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] total;
    logic              ovf;
  } item_t;

  typedef enum logic [1:0] {
    PH_SEQ,
    PH_TOTAL,
    PH_DATA
  } phase_t;

endpackage

### sv/mfrag_front.sv
// Front end of the message fragmenter: accepts input bytes and computes the
// fragment count and overflow flag of each byte's message length.
// Depends on mfrag_pkg.
module mfrag_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [mfrag_pkg::BYTE_W-1:0]  data_byte,
  input  logic [mfrag_pkg::LEN_W-1:0]   msg_length,
  input  logic [mfrag_pkg::BYTE_W-1:0]  dest_id,
  output logic                          item_valid,
  input  logic                          item_ready,
  output mfrag_pkg::item_t              item
);
  import mfrag_pkg::*;

  logic                 s1_valid;
  logic [BYTE_W-1:0]    s1_data;
  logic [BYTE_W-1:0]    s1_dest;
  logic [LEN_W-1:0]     s1_len;
  logic [PROD_W-1:0]    s1_prod;

  logic                 take;
  logic [LEN_W-1:0]     len_m1;
  logic [PROD_W-1:0]    quot;

  assign full = s1_valid && !item_ready;
  assign take = push && !full;

  assign len_m1 = (msg_length == '0) ? '0 : msg_length - LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (item_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_data <= data_byte;
      s1_dest <= dest_id;
      s1_len  <= (msg_length == '0) ? LEN_W'(1) : msg_length;
      s1_prod <= PROD_W'(len_m1) * PROD_W'(RECIP_MULT);
    end
  end

  assign quot       = s1_prod >> RECIP_SHIFT;
  assign item_valid = s1_valid;

  always_comb begin
    item.data  = s1_data;
    item.dest  = s1_dest;
    item.len   = s1_len;
    item.total = quot[BYTE_W-1:0] + BYTE_W'(1);
    item.ovf   = quot >= PROD_W'(COUNT_MAX);
  end

endmodule

### sv/mfrag_fifo.sv
// Short queue between the front end and the fragment sequencer.
// Depends on mfrag_pkg.
module mfrag_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  mfrag_pkg::item_t wr_item,
  output logic             rd_valid,
  input  logic             rd_pop,
  output mfrag_pkg::item_t rd_item
);
  import mfrag_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               wr_en;
  logic               rd_en;

  assign wr_ready = count != (FIFO_AW+1)'(FIFO_DEPTH);
  assign rd_valid = count != '0;
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_pop && rd_valid;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

### sv/mfrag_back.sv
// Fragment sequencer: inserts the two header bytes before each fragment,
// tracks message and fragment position, and holds the result byte register.
// Depends on mfrag_pkg.
module mfrag_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_pop,
  input  mfrag_pkg::item_t              item,
  output logic                          empty,
  input  logic                          pop,
  output logic [mfrag_pkg::BYTE_W-1:0]  dest_id_out,
  output logic [mfrag_pkg::BYTE_W-1:0]  out_byte,
  output logic                          fragment_end,
  output logic                          message_end,
  output logic                          count_overflow
);
  import mfrag_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [LEN_W-1:0]  bytes_sent;
  logic [BYTE_W-1:0] seq;
  logic [BYTE_W-1:0] total;
  logic [BYTE_W-1:0] pos;
  logic              ovf;
  logic              out_valid;

  logic              new_msg;
  logic [BYTE_W-1:0] cur_seq;
  logic [BYTE_W-1:0] cur_total;
  logic [BYTE_W-1:0] cur_pos;
  logic              cur_ovf;
  logic              need_hdr;
  logic [LEN_W-1:0]  bs1;
  logic [BYTE_W-1:0] pos1;
  logic              last;
  logic              fend;
  logic              emit;

  logic              is_data;
  logic [BYTE_W-1:0] sel_byte;
  logic              sel_fend;
  logic              sel_mend;
  logic [LEN_W-1:0]  bytes_sent_next;
  logic [BYTE_W-1:0] seq_next;
  logic [BYTE_W-1:0] pos_next;

  assign new_msg   = bytes_sent == '0;
  assign cur_seq   = new_msg ? SEQ_FIRST : seq;
  assign cur_total = new_msg ? item.total : total;
  assign cur_ovf   = new_msg ? item.ovf : ovf;
  assign cur_pos   = new_msg ? '0 : pos;
  assign need_hdr  = cur_pos == '0;

  assign bs1  = bytes_sent + LEN_W'(1);
  assign pos1 = cur_pos + BYTE_W'(1);
  assign last = bs1 >= item.len;
  assign fend = last || (pos1 >= PAYLOAD_LIM);

  assign emit = item_valid && (!out_valid || pop);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SEQ: begin
        if (emit && need_hdr) begin
          phase_next = PH_TOTAL;
        end
      end
      PH_TOTAL: begin
        if (emit) begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (emit) begin
          phase_next = PH_SEQ;
        end
      end
      default: phase_next = PH_SEQ;
    endcase
  end

  always_comb begin
    is_data  = 1'b0;
    sel_byte = item.data;
    sel_fend = 1'b0;
    sel_mend = 1'b0;
    unique case (phase)
      PH_SEQ: begin
        if (need_hdr) begin
          sel_byte = cur_seq;
        end else begin
          is_data  = 1'b1;
          sel_fend = fend;
          sel_mend = last;
        end
      end
      PH_TOTAL: begin
        sel_byte = cur_total;
      end
      PH_DATA: begin
        is_data  = 1'b1;
        sel_fend = fend;
        sel_mend = last;
      end
      default: begin
        sel_byte = cur_seq;
      end
    endcase
  end

  assign item_pop = emit && is_data;

  always_comb begin
    bytes_sent_next = bytes_sent;
    seq_next        = cur_seq;
    pos_next        = cur_pos;
    if (is_data) begin
      bytes_sent_next = last ? '0 : bs1;
      pos_next        = fend ? '0 : pos1;
      seq_next        = (fend && !last) ? cur_seq + BYTE_W'(1) : cur_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SEQ;
      bytes_sent <= '0;
      seq        <= '0;
      total      <= '0;
      pos        <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit) begin
        bytes_sent <= bytes_sent_next;
        seq        <= seq_next;
        total      <= cur_total;
        pos        <= pos_next;
        ovf        <= cur_ovf;
        out_valid  <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dest_id_out    <= item.dest;
      out_byte       <= sel_byte;
      fragment_end   <= sel_fend;
      message_end    <= sel_mend;
      count_overflow <= cur_ovf;
    end
  end

  assign empty = !out_valid;

  a_total_after_seq: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TOTAL) |-> ($past(phase) == PH_SEQ || $past(phase) == PH_TOTAL))
    else $error("total header without sequence header");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos < PAYLOAD_LIM)
    else $error("fragment position beyond payload size");

  a_msg_end_frag_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_end) |-> fragment_end)
    else $error("message end without fragment end");

endmodule

### sv/message_fragmenter.sv
// Message fragmenter top level: front end, queue and fragment sequencer.
// Depends on mfrag_pkg, mfrag_front, mfrag_fifo and mfrag_back.
//
// Bytes of a message enter one per cycle while full is low; the block cuts
// the message into fragments of FRAME_BYTES-2 payload bytes, each led by a
// sequence byte and a total-count byte. The result side delivers one byte per
// cycle while pop is high, from a single output register, so the input is
// held back while the two header bytes of each fragment go out. The front end
// computes the fragment count with one reciprocal multiply in its register
// stage; a four-entry queue lets input run ahead while headers go out. A byte
// passes the front-end register, the queue and the output register in order.
module message_fragmenter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [mfrag_pkg::BYTE_W-1:0]  data_byte,
  input  logic [mfrag_pkg::LEN_W-1:0]   msg_length,
  input  logic [mfrag_pkg::BYTE_W-1:0]  dest_id,
  output logic                          empty,
  input  logic                          pop,
  output logic [mfrag_pkg::BYTE_W-1:0]  dest_id_out,
  output logic [mfrag_pkg::BYTE_W-1:0]  out_byte,
  output logic                          fragment_end,
  output logic                          message_end,
  output logic                          count_overflow
);
  import mfrag_pkg::*;

  item_t front_item;
  logic  front_valid;
  logic  front_ready;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  mfrag_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .data_byte  (data_byte),
    .msg_length (msg_length),
    .dest_id    (dest_id),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  mfrag_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_item  (front_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  mfrag_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (q_valid),
    .item_pop       (q_pop),
    .item           (q_item),
    .empty          (empty),
    .pop            (pop),
    .dest_id_out    (dest_id_out),
    .out_byte       (out_byte),
    .fragment_end   (fragment_end),
    .message_end    (message_end),
    .count_overflow (count_overflow)
  );

endmodule

### sim/tb_message_fragmenter.sv
// Testbench for message_fragmenter: directed table, then random messages checked against
// a fragmenting predictor, with random gaps on both queue interfaces but in a last calm phase.
// Depends on mfrag_pkg and message_fragmenter.
module tb_message_fragmenter;
  import mfrag_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] dest;
    logic [BYTE_W-1:0] value;
    logic              fend;
    logic              mend;
    logic              ovf;
  } frag_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] dest;
    logic [1:0]        n_typed;
    frag_byte_t [0:2]  typed;
  } stim_row_t;

  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 240;
  localparam int PRESSURE_AT    = 120;
  localparam int CALM_ITEMS     = 40;
  localparam longint CYCLE_LIMIT = 200_000;

  localparam stim_row_t DIRECTED [16] = '{
    '{8'hA5, 16'd1, 8'h3C, 2'd3, '{'{8'h3C, 8'h01, 1'b0, 1'b0, 1'b0},
                                   '{8'h3C, 8'h01, 1'b0, 1'b0, 1'b0},
                                   '{8'h3C, 8'hA5, 1'b1, 1'b1, 1'b0}}},
    '{8'h00, 16'd0, 8'h00, 2'd3, '{'{8'h00, 8'h01, 1'b0, 1'b0, 1'b0},
                                   '{8'h00, 8'h01, 1'b0, 1'b0, 1'b0},
                                   '{8'h00, 8'h00, 1'b1, 1'b1, 1'b0}}},
    '{8'hFF, 16'hFFFF, 8'hFF, 2'd3, '{'{8'hFF, 8'h01, 1'b0, 1'b0, 1'b1},
                                      '{8'hFF, 8'h9D, 1'b0, 1'b0, 1'b1},
                                      '{8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1}}},
    '{8'h5A, 16'd1, 8'hFF, 2'd1, '{'{8'hFF, 8'h5A, 1'b1, 1'b1, 1'b1}, '0, '0}},
    '{8'h12, 16'd2, 8'h80, 2'd0, '0},
    '{8'h34, 16'd2, 8'h7F, 2'd0, '0},
    '{8'h01, 16'd2, 8'h55, 2'd0, '0},
    '{8'h02, 16'd5, 8'h55, 2'd0, '0},
    '{8'h03, 16'd3, 8'h55, 2'd0, '0},
    '{8'hFF, 16'h8000, 8'hAA, 2'd0, '0},
    '{8'h00, 16'h7FFF, 8'h01, 2'd0, '0},
    '{8'h80, 16'd2, 8'h01, 2'd0, '0},
    '{8'h7E, 16'd24990, 8'h02, 2'd0, '0},
    '{8'h81, 16'd1, 8'h02, 2'd0, '0},
    '{8'hC3, 16'd24991, 8'h03, 2'd0, '0},
    '{8'h3C, 16'd0, 8'h03, 2'd0, '0}
  };

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  msg_length;
  logic [BYTE_W-1:0] dest_id;
  logic              empty;
  logic              pop;
  logic [BYTE_W-1:0] dest_id_out;
  logic [BYTE_W-1:0] out_byte;
  logic              fragment_end;
  logic              message_end;
  logic              count_overflow;

  logic [LEN_W-1:0]  msg_done;
  logic [BYTE_W-1:0] frag_seq;
  logic [BYTE_W-1:0] frag_total;
  logic [BYTE_W-1:0] frag_fill;
  logic              msg_ovf;

  frag_byte_t        expected_bytes[$];
  frag_byte_t [0:2]  typed_bytes;
  int                typed_count;
  int                items_sent;
  int                errors;
  longint            cycle_count;
  bit                tx_idling;
  bit                rx_idling;

  message_fragmenter dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .msg_length     (msg_length),
    .dest_id        (dest_id),
    .empty          (empty),
    .pop            (pop),
    .dest_id_out    (dest_id_out),
    .out_byte       (out_byte),
    .fragment_end   (fragment_end),
    .message_end    (message_end),
    .count_overflow (count_overflow)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic fragment_byte(input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] l,
                               input logic [BYTE_W-1:0] id, output frag_byte_t res[3],
                               output int n);
    int   eff_len;
    int   total;
    logic last;
    logic fend;
    eff_len = (l == '0) ? 1 : int'(l);
    if (msg_done == '0) begin
      total = (eff_len + PAYLOAD_BYTES - 1) / PAYLOAD_BYTES;
      msg_ovf = total > int'(COUNT_MAX);
      frag_total = total[BYTE_W-1:0];
      frag_seq = SEQ_FIRST;
      frag_fill = '0;
    end
    n = 0;
    if (frag_fill == '0) begin
      res[0] = '{id, frag_seq, 1'b0, 1'b0, msg_ovf};
      res[1] = '{id, frag_total, 1'b0, 1'b0, msg_ovf};
      n = 2;
    end
    msg_done = msg_done + 1'b1;
    frag_fill = frag_fill + 1'b1;
    last = int'(msg_done) >= eff_len;
    fend = last || frag_fill >= PAYLOAD_LIM;
    res[n] = '{id, d, fend, last, msg_ovf};
    n++;
    if (fend) begin
      frag_fill = '0;
      if (!last) frag_seq = frag_seq + 1'b1;
    end
    if (last) msg_done = '0;
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frag_byte_t predicted[3];
    int         n_pred;
    if (rst) begin
      msg_done <= '0;
      frag_seq <= '0;
      frag_total <= '0;
      frag_fill <= '0;
      msg_ovf <= 1'b0;
    end else if (push && !full) begin
      fragment_byte(data_byte, msg_length, dest_id, predicted, n_pred);
      if (typed_count > 0) begin
        for (int i = 0; i < typed_count; i++) expected_bytes.push_back(typed_bytes[i]);
      end else begin
        for (int i = 0; i < n_pred; i++) expected_bytes.push_back(predicted[i]);
      end
    end
  end

  always @(posedge clk) begin
    frag_byte_t want;
    if (!rst && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected transaction: out_byte %0h", out_byte);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("dest_id_out", want.dest, dest_id_out);
        check_field("out_byte", want.value, out_byte);
        check_field("fragment_end", BYTE_W'(want.fend), BYTE_W'(fragment_end));
        check_field("message_end", BYTE_W'(want.mend), BYTE_W'(message_end));
        check_field("count_overflow", BYTE_W'(want.ovf), BYTE_W'(count_overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int stall_left;
    pop = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (rx_idling && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 14);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] l,
                           input logic [BYTE_W-1:0] id);
    data_byte <= d;
    msg_length <= l;
    dest_id <= id;
    push <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic hold_push(input int cycles);
    push <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_message(input int nbytes, input logic [LEN_W-1:0] l,
                              input logic [BYTE_W-1:0] id, input bit noisy);
    logic [LEN_W-1:0] cur_len;
    for (int i = 0; i < nbytes; i++) begin
      cur_len = l;
      if (noisy && $urandom_range(0, 7) == 0) cur_len = LEN_W'($urandom_range(0, 65535));
      if (tx_idling && $urandom_range(0, 7) == 0) hold_push($urandom_range(1, 15));
      send_item(BYTE_W'($urandom), cur_len, id);
    end
  endtask

  task automatic random_message(input bit allow_idle);
    int               kind;
    int               nbytes;
    logic [LEN_W-1:0] l;
    kind = $urandom_range(0, 19);
    if (kind < 12) nbytes = $urandom_range(1, 8);
    else if (kind < 15) nbytes = $urandom_range(9, 40);
    else if (kind < 17) nbytes = PAYLOAD_BYTES - 1 + $urandom_range(0, 2);
    else if (kind == 17) nbytes = 2 * PAYLOAD_BYTES - 1 + $urandom_range(0, 2);
    else nbytes = $urandom_range(1, 30);
    l = LEN_W'(nbytes);
    if (nbytes == 1 && $urandom_range(0, 2) == 0) l = '0;
    // truncate some broken messages so the next one continues the old count
    if (kind >= 18 && $urandom_range(0, 1) == 0) nbytes = $urandom_range(1, nbytes);
    tx_idling = allow_idle && $urandom_range(0, 3) != 0;
    rx_idling = allow_idle && $urandom_range(0, 3) != 0;
    send_message(nbytes, l, BYTE_W'($urandom), kind >= 18);
  endtask

  initial begin
    bit drained;
    rst = 1'b1;
    push = 1'b0;
    data_byte = '0;
    msg_length = '0;
    dest_id = '0;
    typed_count = 0;
    items_sent = 0;
    errors = 0;
    cycle_count = 0;
    tx_idling = 1'b0;
    rx_idling = 1'b1;
    drained = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < $size(DIRECTED); k++) begin
      typed_count = DIRECTED[k].n_typed;
      typed_bytes = DIRECTED[k].typed;
      send_item(DIRECTED[k].data, DIRECTED[k].len, DIRECTED[k].dest);
    end
    typed_count = 0;

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      random_message(1'b1);
      if (!drained && items_sent >= PRESSURE_AT) begin
        push <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge clk);
        drained = 1'b1;
      end
    end

    tx_idling = 1'b0;
    rx_idling = 1'b0;
    items_sent = 0;
    while (items_sent < CALM_ITEMS) random_message(1'b0);

    push <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
